@@ src/sgpc_pkg.sv @@
// shared constants and codes for the stepper gauge position controller
package sgpc_pkg;

    // field and register widths
    localparam int TEMP_W     = 16;
    localparam int STEP_W     = 16;
    localparam int MODE_W     = 2;
    localparam int PHASE_W    = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int COUNT_W    = 3;

    // default breakpoint table depth
    localparam int MAX_POINTS_DEF = 6;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POINT_BASE  = 3'd1;

    // transaction modes
    localparam logic [MODE_W-1:0] MODE_SAMPLE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TICK   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_HOME   = 2'd2;

    // homing phases
    localparam logic [PHASE_W-1:0] PHASE_IDLE  = 2'd0;
    localparam logic [PHASE_W-1:0] PHASE_LEAVE = 2'd1;
    localparam logic [PHASE_W-1:0] PHASE_SEEK  = 2'd2;

    // step directions
    localparam logic DIR_FORWARD  = 1'b0;
    localparam logic DIR_BACKWARD = 1'b1;

endpackage

@@ src/sgpc_if.sv @@
// valid/ready channel interfaces for samples and results

interface sgpc_in_if;
    logic                                   valid;
    logic                                   ready;
    logic [sgpc_pkg::MODE_W-1:0]            mode;
    logic signed [sgpc_pkg::TEMP_W-1:0]     temperature;
    logic                                   button_pressed;

    modport source (output valid, mode, temperature, button_pressed, input ready);
    modport sink   (input valid, mode, temperature, button_pressed, output ready);
endinterface

interface sgpc_out_if;
    logic                                   valid;
    logic                                   ready;
    logic                                   step_pulse;
    logic                                   step_direction;
    logic [sgpc_pkg::STEP_W-1:0]            position;
    logic [sgpc_pkg::STEP_W-1:0]            target;
    logic [sgpc_pkg::PHASE_W-1:0]           homing_phase;

    modport source (output valid, step_pulse, step_direction, position, target, homing_phase,
                    input ready);
    modport sink   (input valid, step_pulse, step_direction, position, target, homing_phase,
                    output ready);
endinterface

@@ src/stepper_gauge_position_controller.sv @@
// stepper gauge position controller: table interpolation, needle stepping and homing
// tick, homing start and unused-mode transactions go straight from the idle state to the output register
// a temperature sample scans one breakpoint per cycle, and an interpolated one then runs a
//   bit-serial multiply, a bit-serial divide and a finish step before its result is registered
// one transaction at a time: a new one is taken only in the idle state, once no result is pending or it is taken
// reset: position, target, homing phase and breakpoints clear, point count becomes 1
module stepper_gauge_position_controller #(
    parameter int MAX_POINTS = sgpc_pkg::MAX_POINTS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [sgpc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sgpc_pkg::CFG_DATA_W-1:0]   cfg_data,
    sgpc_in_if.sink                           sample,
    sgpc_out_if.source                        result
);

    localparam int IDX_W  = $clog2(MAX_POINTS);
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int ITER_W = $clog2(sgpc_pkg::STEP_W);
    localparam int SW     = sgpc_pkg::STEP_W;
    localparam int TW     = sgpc_pkg::TEMP_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_MUL,
        S_DIV,
        S_DONE
    } state_t;

    // configuration registers
    logic [sgpc_pkg::COUNT_W-1:0]    point_count_reg;
    logic [sgpc_pkg::CFG_DATA_W-1:0] points_reg [MAX_POINTS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_count_reg <= sgpc_pkg::COUNT_W'(1);
        end
        else if (cfg_we && cfg_index == sgpc_pkg::REG_POINT_COUNT)
        begin
            point_count_reg <= cfg_data[sgpc_pkg::COUNT_W-1:0];
        end
    end

    for (genvar k = 0; k < MAX_POINTS; k++)
    begin : g_point
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                points_reg[k] <= '0;
            end
            else if (cfg_we &&
                     cfg_index == sgpc_pkg::REG_POINT_BASE + sgpc_pkg::CFG_IDX_W'(k))
            begin
                points_reg[k] <= cfg_data;
            end
        end
    end

    // state and datapath registers
    state_t               state_reg,   state_next;
    logic [SW-1:0]        pos_reg,     pos_next;
    logic [SW-1:0]        target_reg,  target_next;
    logic [sgpc_pkg::PHASE_W-1:0] phase_reg, phase_next;
    logic [TW-1:0]        temp_reg,    temp_next;
    logic [CNT_W-1:0]     idx_reg,     idx_next;
    logic [sgpc_pkg::CFG_DATA_W-1:0] lo_reg, lo_next;
    logic [TW-1:0]        div_reg,     div_next;
    logic [TW-1:0]        off_reg,     off_next;
    logic [SW-1:0]        sl_reg,      sl_next;
    logic [2*SW-1:0]      acc_reg,     acc_next;
    logic [ITER_W-1:0]    iter_reg,    iter_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 out_pulse_reg, out_pulse_next;
    logic                 out_dir_reg,   out_dir_next;

    // effective breakpoint count
    logic [CNT_W-1:0] n_used;
    always_comb
    begin
        if (point_count_reg == '0)
            n_used = CNT_W'(1);
        else if (point_count_reg > sgpc_pkg::COUNT_W'(MAX_POINTS))
            n_used = CNT_W'(MAX_POINTS);
        else
            n_used = CNT_W'(point_count_reg);
    end

    // handshake
    logic in_fire;
    assign sample.ready = (state_reg == S_IDLE) && (!out_valid_reg || result.ready);
    assign in_fire      = sample.valid && sample.ready;

    // breakpoint under scan
    logic [sgpc_pkg::CFG_DATA_W-1:0] pt;
    logic                            temp_le;
    assign pt      = points_reg[idx_reg[IDX_W-1:0]];
    assign temp_le = $signed(temp_reg) <= $signed(pt[31:16]);

    // multiply and divide steps
    logic [SW:0] mul_sum;
    logic [SW:0] div_trial;
    logic [SW:0] div_diff;
    logic        div_ge;
    assign mul_sum   = {1'b0, acc_reg[2*SW-1:SW]} + (acc_reg[0] ? {1'b0, off_reg} : '0);
    assign div_trial = acc_reg[2*SW-1:SW-1];
    assign div_diff  = div_trial - {1'b0, div_reg};
    assign div_ge    = div_trial >= {1'b0, div_reg};

    // next-state logic
    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        target_next    = target_reg;
        phase_next     = phase_reg;
        temp_next      = temp_reg;
        idx_next       = idx_reg;
        lo_next        = lo_reg;
        div_next       = div_reg;
        off_next       = off_reg;
        sl_next        = sl_reg;
        acc_next       = acc_reg;
        iter_next      = iter_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_pulse_next = out_pulse_reg;
        out_dir_next   = out_dir_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    out_pulse_next = 1'b0;
                    out_dir_next   = sgpc_pkg::DIR_FORWARD;
                    case (sample.mode)
                        sgpc_pkg::MODE_SAMPLE:
                        begin
                            temp_next  = sample.temperature;
                            idx_next   = '0;
                            state_next = S_SEARCH;
                        end
                        sgpc_pkg::MODE_TICK:
                        begin
                            out_valid_next = 1'b1;
                            if (phase_reg == sgpc_pkg::PHASE_LEAVE)
                            begin
                                out_pulse_next = 1'b1;
                                if (!sample.button_pressed)
                                begin
                                    phase_next   = sgpc_pkg::PHASE_SEEK;
                                    out_dir_next = sgpc_pkg::DIR_BACKWARD;
                                end
                            end
                            else if (phase_reg == sgpc_pkg::PHASE_SEEK)
                            begin
                                if (!sample.button_pressed)
                                begin
                                    out_pulse_next = 1'b1;
                                    out_dir_next   = sgpc_pkg::DIR_BACKWARD;
                                end
                                else
                                begin
                                    pos_next   = '0;
                                    phase_next = sgpc_pkg::PHASE_IDLE;
                                end
                            end
                            else if (pos_reg < target_reg)
                            begin
                                pos_next       = pos_reg + SW'(1);
                                out_pulse_next = 1'b1;
                            end
                            else if (pos_reg > target_reg)
                            begin
                                pos_next       = pos_reg - SW'(1);
                                out_pulse_next = 1'b1;
                                out_dir_next   = sgpc_pkg::DIR_BACKWARD;
                            end
                        end
                        sgpc_pkg::MODE_HOME:
                        begin
                            out_valid_next = 1'b1;
                            phase_next     = sample.button_pressed ? sgpc_pkg::PHASE_LEAVE
                                                                   : sgpc_pkg::PHASE_SEEK;
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                        end
                    endcase
                end
            end

            // one breakpoint per cycle, previous one kept in lo_reg
            S_SEARCH:
            begin
                if (idx_reg == n_used)
                begin
                    target_next    = lo_reg[SW-1:0];
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
                else if (temp_le)
                begin
                    if (idx_reg == '0)
                    begin
                        target_next    = '0;
                        out_valid_next = 1'b1;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        div_next   = pt[31:16] - lo_reg[31:16];
                        off_next   = temp_reg - lo_reg[31:16];
                        sl_next    = lo_reg[SW-1:0];
                        acc_next   = {{SW{1'b0}}, pt[SW-1:0] - lo_reg[SW-1:0]};
                        iter_next  = '0;
                        state_next = S_MUL;
                    end
                end
                else
                begin
                    lo_next  = pt;
                    idx_next = idx_reg + CNT_W'(1);
                end
            end

            // shift-add multiply, one multiplier bit per cycle
            S_MUL:
            begin
                acc_next  = {mul_sum, acc_reg[SW-1:1]};
                iter_next = iter_reg + ITER_W'(1);
                if (iter_reg == ITER_W'(SW - 1))
                begin
                    state_next = S_DIV;
                end
            end

            // restoring divide, one quotient bit per cycle
            S_DIV:
            begin
                acc_next  = {div_ge ? div_diff[SW-1:0] : div_trial[SW-1:0],
                             acc_reg[SW-2:0], div_ge};
                iter_next = iter_reg + ITER_W'(1);
                if (iter_reg == ITER_W'(SW - 1))
                begin
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                target_next    = sl_reg + acc_reg[SW-1:0];
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pos_reg       <= '0;
            target_reg    <= '0;
            phase_reg     <= sgpc_pkg::PHASE_IDLE;
            idx_reg       <= '0;
            iter_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_pulse_reg <= 1'b0;
            out_dir_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            target_reg    <= target_next;
            phase_reg     <= phase_next;
            idx_reg       <= idx_next;
            iter_reg      <= iter_next;
            out_valid_reg <= out_valid_next;
            out_pulse_reg <= out_pulse_next;
            out_dir_reg   <= out_dir_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        temp_reg <= temp_next;
        lo_reg   <= lo_next;
        div_reg  <= div_next;
        off_reg  <= off_next;
        sl_reg   <= sl_next;
        acc_reg  <= acc_next;
    end

    // result channel
    assign result.valid          = out_valid_reg;
    assign result.step_pulse     = out_pulse_reg;
    assign result.step_direction = out_dir_reg;
    assign result.position       = pos_reg;
    assign result.target         = target_reg;
    assign result.homing_phase   = phase_reg;

    // checks
    a_busy_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> !out_valid_reg)
        else $error("result pending while a sample is in progress");

    a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        sample.ready |-> state_reg == S_IDLE)
        else $error("input ready while busy");

    a_dir_needs_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_pulse_reg |-> out_dir_reg == sgpc_pkg::DIR_FORWARD)
        else $error("backward direction without a step");

    a_pos_moves_on_tx: assert property (@(posedge clk) disable iff (!rst_n)
        !in_fire |=> $stable(pos_reg))
        else $error("position changed without a transaction");

endmodule
